// File: rtl/cpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

   localparam int FRAMES_DEF     = 16;
   localparam int PAGE_BITS_DEF  = 16;

   localparam int PAGE_NUM_W     = 16;
   localparam int FRAME_IDX_W    = 4;
   localparam int FAULT_W        = 32;
   localparam int CSR_W          = 5;
   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(16);

   typedef enum logic [1:0] {
      LAP_LOOKUP,
      LAP_SWEEP,
      LAP_WRAP
   } lap_type;

   typedef struct packed {
      logic    valid;
      lap_type lap;
      logic    found;
      logic    cold;
   } tok_ctl_type;

   typedef struct packed {
      logic                   hit;
      logic                   cold_fill;
      logic                   page_fault;
      logic [FRAME_IDX_W-1:0] frame_index;
      logic [PAGE_NUM_W-1:0]  evicted_page;
      logic [FAULT_W-1:0]     fault_total;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/cpr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module cpr_cell
   import cpr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF,
   parameter int IDX       = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tok_ctl_type          tok_ctl_i,
   input  wire logic [PAGE_BITS-1:0] tok_page_i,
   input  wire logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] tok_frame_i,
   input  wire logic [PAGE_BITS-1:0] tok_evict_i,
   input  wire logic [$clog2(FRAMES+1)-1:0] count_i,
   input  wire logic [$clog2(FRAMES+1)-1:0] used_i,
   input  wire logic                 do_fill_i,
   input  wire logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] pos_i,
   output tok_ctl_type               tok_ctl_o,
   output logic [PAGE_BITS-1:0]      tok_page_o,
   output logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] tok_frame_o,
   output logic [PAGE_BITS-1:0]      tok_evict_o
);

   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW = $clog2(FRAMES + 1);

   logic [PAGE_BITS-1:0] page_ff;
   logic                 ref_ff;
   tok_ctl_type          tok_ctl_ff;
   logic [PAGE_BITS-1:0] tok_page_ff;
   logic [IW-1:0]        tok_frame_ff;
   logic [PAGE_BITS-1:0] tok_evict_ff;

   tok_ctl_type          ctl_in;
   logic [IW-1:0]        frame_in;
   logic [PAGE_BITS-1:0] evict_in;
   logic                 page_wr;
   logic                 ref_set;
   logic                 ref_clr;
   logic                 hit_range;
   logic                 fill_here;
   logic                 sweep_range;

   assign hit_range   = CW'(IDX) < used_i;
   assign fill_here   = do_fill_i && (CW'(IDX) == used_i);
   assign sweep_range = ((tok_ctl_i.lap == LAP_WRAP) || (IW'(IDX) >= pos_i))
                        && (CW'(IDX) < count_i);

   always_comb begin
      ctl_in   = tok_ctl_i;
      frame_in = tok_frame_i;
      evict_in = tok_evict_i;
      page_wr  = 1'b0;
      ref_set  = 1'b0;
      ref_clr  = 1'b0;
      if (tok_ctl_i.valid && !tok_ctl_i.found) begin
         unique case (tok_ctl_i.lap)
            LAP_LOOKUP: begin
               if (hit_range && (page_ff == tok_page_i)) begin
                  ctl_in.found = 1'b1;
                  frame_in     = IW'(IDX);
                  ref_set      = 1'b1;
               end else if (fill_here) begin
                  ctl_in.found = 1'b1;
                  ctl_in.cold  = 1'b1;
                  frame_in     = IW'(IDX);
                  page_wr      = 1'b1;
                  ref_set      = 1'b1;
               end
            end
            LAP_SWEEP, LAP_WRAP: begin
               if (sweep_range) begin
                  if (ref_ff) begin
                     ref_clr = 1'b1;
                  end else begin
                     ctl_in.found = 1'b1;
                     frame_in     = IW'(IDX);
                     evict_in     = page_ff;
                     page_wr      = 1'b1;
                     ref_set      = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff     <= 1'b0;
         tok_ctl_ff <= '0;
      end else begin
         tok_ctl_ff <= ctl_in;
         if (ref_set) begin
            ref_ff <= 1'b1;
         end else if (ref_clr) begin
            ref_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_page_ff  <= tok_page_i;
      tok_frame_ff <= frame_in;
      tok_evict_ff <= evict_in;
      if (page_wr) begin
         page_ff <= tok_page_i;
      end
   end

   assign tok_ctl_o   = tok_ctl_ff;
   assign tok_page_o  = tok_page_ff;
   assign tok_frame_o = tok_frame_ff;
   assign tok_evict_o = tok_evict_ff;

endmodule

`default_nettype wire

// File: rtl/clock_page_replacement_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_page_number
// rsp       out        rsp_valid/stall    rsp_hit, rsp_cold_fill, rsp_page_fault,
//                                         rsp_frame_index, rsp_evicted_page,
//                                         rsp_fault_total
// csr       in         csr_wr_en          csr_wr_data (frame count)
//
// A reference token walks the cell chain one cell per cycle, one lap per pass.
// Hit or cold fill: one lap; fault: two or three laps. When the token leaves the
// last cell, the result loads the output register, or the skid if it stalls.
// One reference is in the chain at a time; the next waits for it and a free skid.
// Synchronous reset clears reference bits, fill count, hand and fault counter.
// A stalled result holds; one further result waits in a skid register.

module clock_page_replacement_top
   import cpr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [PAGE_NUM_W-1:0]  req_page_number,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_hit,
   output logic                        rsp_cold_fill,
   output logic                        rsp_page_fault,
   output logic [FRAME_IDX_W-1:0]      rsp_frame_index,
   output logic [PAGE_NUM_W-1:0]       rsp_evicted_page,
   output logic [FAULT_W-1:0]          rsp_fault_total,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_W-1:0]       csr_wr_data
);

   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW = $clog2(FRAMES + 1);

   logic [CSR_W-1:0]   csr_ff;
   logic               busy_ff;
   logic [CW-1:0]      filled_ff;
   logic [IW-1:0]      hand_ff;
   logic [FAULT_W-1:0] fault_ff;
   logic               rsp_valid_ff;
   result_type         rsp_ff;
   logic               skid_valid_ff;
   result_type         skid_ff;

   tok_ctl_type          tok_ctl   [0:FRAMES];
   logic [PAGE_BITS-1:0] tok_page  [0:FRAMES];
   logic [IW-1:0]        tok_frame [0:FRAMES];
   logic [PAGE_BITS-1:0] tok_evict [0:FRAMES];

   logic [CW-1:0]      count_act;
   logic [CW-1:0]      used;
   logic               do_fill;
   logic [IW-1:0]      pos;
   logic               accept;
   logic               reinject;
   logic               done;
   tok_ctl_type        exit_ctl;
   logic [CW-1:0]      hand_next;
   logic [IW-1:0]      hand_in;
   logic [FAULT_W-1:0] fault_in;
   result_type         res;

   always_comb begin
      priority if (csr_ff == '0) begin
         count_act = CW'(1);
      end else if (32'(csr_ff) > FRAMES) begin
         count_act = CW'(FRAMES);
      end else begin
         count_act = CW'(csr_ff);
      end
   end

   assign do_fill = filled_ff < count_act;
   assign used    = do_fill ? filled_ff : count_act;
   assign pos     = (CW'(hand_ff) < count_act) ? hand_ff : '0;

   assign exit_ctl  = tok_ctl[FRAMES];
   assign req_stall = busy_ff || skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign done      = exit_ctl.valid && exit_ctl.found;
   assign reinject  = exit_ctl.valid && !exit_ctl.found && (exit_ctl.lap != LAP_WRAP);

   always_comb begin
      tok_ctl[0]   = '0;
      tok_page[0]  = tok_page[FRAMES];
      tok_frame[0] = tok_frame[FRAMES];
      tok_evict[0] = tok_evict[FRAMES];
      if (accept) begin
         tok_ctl[0].valid = 1'b1;
         tok_ctl[0].lap   = LAP_LOOKUP;
         tok_page[0]      = PAGE_BITS'(req_page_number);
         tok_frame[0]     = '0;
         tok_evict[0]     = '0;
      end else if (reinject) begin
         tok_ctl[0]     = exit_ctl;
         tok_ctl[0].lap = (exit_ctl.lap == LAP_LOOKUP) ? LAP_SWEEP : LAP_WRAP;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < FRAMES; gi++) begin : g_cell
         cpr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (gi)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .tok_ctl_i   (tok_ctl[gi]),
            .tok_page_i  (tok_page[gi]),
            .tok_frame_i (tok_frame[gi]),
            .tok_evict_i (tok_evict[gi]),
            .count_i     (count_act),
            .used_i      (used),
            .do_fill_i   (do_fill),
            .pos_i       (pos),
            .tok_ctl_o   (tok_ctl[gi+1]),
            .tok_page_o  (tok_page[gi+1]),
            .tok_frame_o (tok_frame[gi+1]),
            .tok_evict_o (tok_evict[gi+1])
         );
      end
   endgenerate

   assign hand_next = CW'(tok_frame[FRAMES]) + CW'(1);
   assign hand_in   = (hand_next == count_act) ? '0 : IW'(hand_next);
   assign fault_in  = (fault_ff == '1) ? fault_ff : fault_ff + FAULT_W'(1);

   always_comb begin
      res.hit          = !exit_ctl.cold && (exit_ctl.lap == LAP_LOOKUP);
      res.cold_fill    = exit_ctl.cold;
      res.page_fault   = exit_ctl.lap != LAP_LOOKUP;
      res.frame_index  = FRAME_IDX_W'(tok_frame[FRAMES]);
      res.evicted_page = PAGE_NUM_W'(tok_evict[FRAMES]);
      res.fault_total  = res.page_fault ? fault_in : fault_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff        <= CSR_RESET;
         busy_ff       <= 1'b0;
         filled_ff     <= '0;
         hand_ff       <= '0;
         fault_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         if (accept) begin
            busy_ff <= 1'b1;
         end
         if (done) begin
            busy_ff <= 1'b0;
            if (exit_ctl.cold) begin
               filled_ff <= filled_ff + CW'(1);
            end
            if (exit_ctl.lap != LAP_LOOKUP) begin
               hand_ff  <= hand_in;
               fault_ff <= fault_in;
            end
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end else if (rsp_valid_ff && !rsp_stall && skid_valid_ff) begin
         rsp_ff <= skid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_ff.hit;
   assign rsp_cold_fill    = rsp_ff.cold_fill;
   assign rsp_page_fault   = rsp_ff.page_fault;
   assign rsp_frame_index  = rsp_ff.frame_index;
   assign rsp_evicted_page = rsp_ff.evicted_page;
   assign rsp_fault_total  = rsp_ff.fault_total;

   a_wrap_found: assert property (@(posedge clock) disable iff (reset)
      exit_ctl.valid && (exit_ctl.lap == LAP_WRAP) |-> exit_ctl.found)
      else $error("wrap lap ended without a victim");

   a_fill_found: assert property (@(posedge clock) disable iff (reset)
      exit_ctl.valid && (exit_ctl.lap == LAP_LOOKUP) && do_fill |-> exit_ctl.found)
      else $error("lookup lap with a free frame ended unresolved");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full with output register empty");

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      exit_ctl.valid |-> busy_ff && !accept)
      else $error("token in chain while idle or new transfer taken");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CW'(FRAMES))
      else $error("fill count beyond frame table");

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import cpr_pkg::*;

   localparam int NFRAMES       = FRAMES_DEF;
   localparam int SETTLE_CYCLES = 3 * NFRAMES + 8;
   localparam int QUIET_LIMIT   = 4000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PAGE_NUM_W-1:0]  req_page_number = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_hit;
   logic                   rsp_cold_fill;
   logic                   rsp_page_fault;
   logic [FRAME_IDX_W-1:0] rsp_frame_index;
   logic [PAGE_NUM_W-1:0]  rsp_evicted_page;
   logic [FAULT_W-1:0]     rsp_fault_total;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_W-1:0]       csr_wr_data = '0;

   logic                   idle_on = 1'b1;
   int                     errors = 0;
   int                     quiet_cycles = 0;
   result_type             expected_refs[$];

   logic [PAGE_NUM_W-1:0]  resident_page [NFRAMES];
   logic                   ref_bit [NFRAMES] = '{default: 1'b0};
   int                     frames_used = 0;
   int                     hand_pos = 0;
   logic [FAULT_W-1:0]     fault_count = '0;
   logic [CSR_W-1:0]       active_frames = CSR_RESET;

   clock_page_replacement_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_cold_fill   (rsp_cold_fill),
      .rsp_page_fault  (rsp_page_fault),
      .rsp_frame_index (rsp_frame_index),
      .rsp_evicted_page(rsp_evicted_page),
      .rsp_fault_total (rsp_fault_total),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type predict_reference(input logic [PAGE_NUM_W-1:0] page);
      result_type r;
      int         cnt;
      int         used;
      int         pos;
      int         steps;
      r = '0;
      cnt = (active_frames < 1) ? 1 : (active_frames > NFRAMES) ? NFRAMES : int'(active_frames);
      used = (frames_used < cnt) ? frames_used : cnt;
      for (int i = 0; i < used; i++) begin
         if (!r.hit && resident_page[i] == page) begin
            r.hit = 1'b1;
            r.frame_index = FRAME_IDX_W'(i);
         end
      end
      if (r.hit) begin
         ref_bit[r.frame_index] = 1'b1;
      end else if (frames_used < cnt) begin
         r.cold_fill = 1'b1;
         r.frame_index = FRAME_IDX_W'(frames_used);
         resident_page[frames_used] = page;
         ref_bit[frames_used] = 1'b1;
         frames_used++;
      end else begin
         pos = (hand_pos < cnt) ? hand_pos : 0;
         steps = 0;
         while (steps < 2 * cnt && ref_bit[pos]) begin
            ref_bit[pos] = 1'b0;
            pos = (pos + 1 == cnt) ? 0 : pos + 1;
            steps++;
         end
         r.page_fault = 1'b1;
         r.frame_index = FRAME_IDX_W'(pos);
         r.evicted_page = resident_page[pos];
         resident_page[pos] = page;
         ref_bit[pos] = 1'b1;
         hand_pos = (pos + 1 == cnt) ? 0 : pos + 1;
         if (fault_count != '1) fault_count++;
      end
      r.fault_total = fault_count;
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [FAULT_W-1:0] want,
                                input logic [FAULT_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t tb: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall = idle_on && ($urandom_range(99) < 26);
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_refs.size() == 0) begin
            errors++;
            $display("%0t tb: result transfer with nothing expected", $time);
         end else begin
            want = expected_refs.pop_front();
            compare_field("hit", want.hit, rsp_hit);
            compare_field("cold_fill", want.cold_fill, rsp_cold_fill);
            compare_field("page_fault", want.page_fault, rsp_page_fault);
            compare_field("frame_index", want.frame_index, rsp_frame_index);
            compare_field("evicted_page", want.evicted_page, rsp_evicted_page);
            compare_field("fault_total", want.fault_total, rsp_fault_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue_reference(input logic [PAGE_NUM_W-1:0] page);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 26) begin
         req_valid = 1'b0;
         req_page_number = PAGE_NUM_W'($urandom);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_page_number = page;
      do @(posedge clock); while (req_stall);
      expected_refs.insert(expected_refs.size(), predict_reference(page));
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_refs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_frame_count(input logic [CSR_W-1:0] value);
      drain_pipeline();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      active_frames = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic test_fill_hit_fault();
      program_frame_count(CSR_W'(2));
      issue_reference(16'h0000);
      issue_reference(16'hFFFF);
      issue_reference(16'hFFFF);
      // every reference bit set: sweep clears both and replaces the start frame
      issue_reference(16'h1234);
      issue_reference(16'hABCD);
   endtask

   task automatic test_zero_count();
      program_frame_count(CSR_W'(0));
      issue_reference(16'h1234);
      issue_reference(16'h5555);
   endtask

   task automatic test_lowered_count();
      program_frame_count(CSR_W'(4));
      issue_reference(16'h0101);
      issue_reference(16'h0202);
      issue_reference(16'h0303);
      issue_reference(16'h0404);
      issue_reference(16'h0505);
      issue_reference(16'h0606);
      // hand now past the lowered count; upper frames keep their pages
      program_frame_count(CSR_W'(2));
      issue_reference(16'h0303);
   endtask

   task automatic test_duplicate_frames();
      program_frame_count(CSR_W'(4));
      issue_reference(16'h0303);
      issue_reference(16'h0505);
   endtask

   task automatic test_oversized_count();
      program_frame_count(CSR_W'(31));
      issue_reference(16'h7FFF);
      issue_reference(16'h8000);
      issue_reference(16'h0202);
   endtask

   task automatic test_random_phase(input int count, input int n, input bit idles);
      int                    eff;
      int                    span;
      logic [PAGE_NUM_W-1:0] base;
      program_frame_count(CSR_W'(count));
      idle_on = idles;
      eff = (count < 1) ? 1 : (count > NFRAMES) ? NFRAMES : count;
      span = eff + 1 + $urandom_range(eff);
      base = PAGE_NUM_W'($urandom);
      for (int k = 0; k < n; k++) begin
         if (k == n / 2) drain_pipeline();
         if ($urandom_range(99) < 5) base = PAGE_NUM_W'($urandom);
         if ($urandom_range(99) < 80)
            issue_reference(base + PAGE_NUM_W'($urandom_range(span - 1)));
         else
            issue_reference(PAGE_NUM_W'($urandom));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_fill_hit_fault();
      test_zero_count();
      test_lowered_count();
      test_duplicate_frames();
      test_oversized_count();
      test_random_phase(16, 100, 1'b1);
      test_random_phase(1, 100, 1'b1);
      test_random_phase(31, 100, 1'b0);
      test_random_phase(0, 100, 1'b1);
      test_random_phase(5, 100, 1'b1);
      test_random_phase(17, 100, 1'b1);
      test_random_phase($urandom_range(15, 2), 100, 1'b1);
      test_random_phase(8, 100, 1'b1);
      drain_pipeline();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/cpr_pkg.sv
rtl/cpr_cell.sv
rtl/clock_page_replacement_top.sv
test/tb.sv
